// File: rtl/core/fcm_pkg.sv
// Shared types and constants of the frame checksum and counter monitor.
// Used by the channel interfaces and by every module of the block.
package fcm_pkg;

    localparam int FRAME_BYTE_W = 8;
    localparam int TIME_W       = 32;
    localparam int TIMEOUT_W    = 16;
    localparam int SPEED_W      = 16;
    localparam int COUNT_W      = 4;
    localparam int STATUS_W     = 2;

    localparam logic [TIMEOUT_W-1:0]    TIMEOUT_RESET = TIMEOUT_W'(100);
    localparam logic [FRAME_BYTE_W-1:0] CSUM_BASE     = 8'hFF;

    // Depth of the queue between the front and back parts.
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic {
        CMD_FRAME = 1'b0,
        CMD_TICK  = 1'b1
    } command_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK   = 2'd0,
        STATUS_CSUM = 2'd1,
        STATUS_GAP  = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        KIND_TICK = 2'd0,
        KIND_BAD  = 2'd1,
        KIND_GOOD = 2'd2
    } kind_t;

    // One classified word as it waits in the queue.
    typedef struct packed {
        kind_t                    kind;
        logic [TIME_W-1:0]        now_ms;
        logic [FRAME_BYTE_W-1:0]  gear_code;
        logic [SPEED_W-1:0]       speed_x10;
        logic [FRAME_BYTE_W-1:0]  throttle;
        logic [FRAME_BYTE_W-1:0]  sender_faults;
        logic [COUNT_W-1:0]       rolling_count;
    } entry_t;

    // Monitor state as seen from outside the back part.
    typedef struct packed {
        logic seen_frame;
        logic checksum_fault;
        logic timeout_fault;
    } mon_status_t;

endpackage

// File: rtl/core/fcm_interfaces.sv
// Valid/ready channel interfaces of the frame checksum and counter monitor.
// Depends on fcm_pkg for field widths.
interface fcm_item_if import fcm_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic                    command;
    logic [TIME_W-1:0]       now_ms;
    logic [FRAME_BYTE_W-1:0] frame_byte0;
    logic [FRAME_BYTE_W-1:0] frame_byte1;
    logic [FRAME_BYTE_W-1:0] frame_byte2;
    logic [FRAME_BYTE_W-1:0] frame_byte3;
    logic [FRAME_BYTE_W-1:0] frame_byte4;
    logic [FRAME_BYTE_W-1:0] frame_byte5;
    logic [FRAME_BYTE_W-1:0] frame_byte6;
    logic [FRAME_BYTE_W-1:0] frame_byte7;

    modport source (
        output valid, command, now_ms, frame_byte0, frame_byte1, frame_byte2,
               frame_byte3, frame_byte4, frame_byte5, frame_byte6, frame_byte7,
        input  ready
    );
    modport sink (
        input  valid, command, now_ms, frame_byte0, frame_byte1, frame_byte2,
               frame_byte3, frame_byte4, frame_byte5, frame_byte6, frame_byte7,
        output ready
    );
endinterface

interface fcm_result_if import fcm_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [STATUS_W-1:0]     status;
    logic [FRAME_BYTE_W-1:0] gear_code;
    logic [SPEED_W-1:0]      speed_x10;
    logic [FRAME_BYTE_W-1:0] throttle;
    logic [FRAME_BYTE_W-1:0] sender_faults;
    logic [COUNT_W-1:0]      rolling_count;
    logic                    checksum_fault_flag;
    logic                    timeout_fault_flag;

    modport source (
        output valid, status, gear_code, speed_x10, throttle, sender_faults,
               rolling_count, checksum_fault_flag, timeout_fault_flag,
        input  ready
    );
    modport sink (
        input  valid, status, gear_code, speed_x10, throttle, sender_faults,
               rolling_count, checksum_fault_flag, timeout_fault_flag,
        output ready
    );
endinterface

interface fcm_cfg_if import fcm_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [TIMEOUT_W-1:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

// File: rtl/core/fcm_front.sv
// Front part: takes input words, verifies the checksum and classifies them.
// Depends on fcm_pkg and the item channel interface.
module fcm_front import fcm_pkg::*; (
    fcm_item_if.sink item,
    output logic     push_valid,
    input  logic     push_ready,
    output entry_t   push_entry
);

    logic [FRAME_BYTE_W-1:0] byte_sum;
    logic                    csum_ok;

    // Eight-bit wrapping sum of bytes zero to six.
    assign byte_sum = item.frame_byte0 + item.frame_byte1 + item.frame_byte2
                    + item.frame_byte3 + item.frame_byte4 + item.frame_byte5
                    + item.frame_byte6;
    assign csum_ok  = (item.frame_byte7 == (CSUM_BASE - byte_sum));

    assign push_valid = item.valid;
    assign item.ready = push_ready;

    always_comb
    begin
        push_entry               = '0;
        push_entry.now_ms        = item.now_ms;
        if (item.command == CMD_TICK)
        begin
            push_entry.kind = KIND_TICK;
        end
        else if (!csum_ok)
        begin
            push_entry.kind = KIND_BAD;
        end
        else
        begin
            push_entry.kind          = KIND_GOOD;
            push_entry.gear_code     = item.frame_byte0;
            push_entry.speed_x10     = {item.frame_byte2, item.frame_byte1};
            push_entry.throttle      = item.frame_byte3;
            push_entry.sender_faults = item.frame_byte4;
            push_entry.rolling_count = item.frame_byte6[COUNT_W-1:0];
        end
    end

endmodule

// File: rtl/core/fcm_queue.sv
// Short first-in first-out queue of classified words between front and back.
// Depends on fcm_pkg for the entry type and depth.
module fcm_queue import fcm_pkg::*; (
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push_valid,
    output logic   push_ready,
    input  entry_t push_entry,
    output logic   pop_valid,
    input  logic   pop_ready,
    output entry_t pop_entry
);

    entry_t                 entry_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CNT_W-1:0] count_reg, count_next;
    logic                   do_push;
    logic                   do_pop;

    assign push_ready = (count_reg != QUEUE_CNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_entry  = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                        : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                        : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

// File: rtl/core/fcm_back.sv
// Back part: applies classified words to the monitor state and registers results.
// Depends on fcm_pkg and the result and configuration channel interfaces.
module fcm_back import fcm_pkg::*; (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         pop_valid,
    output logic         pop_ready,
    input  entry_t       pop_entry,
    fcm_result_if.source result,
    fcm_cfg_if.sink      cfg,
    output mon_status_t  mon_status
);

    logic [TIMEOUT_W-1:0] timeout_reg, timeout_next;
    logic [COUNT_W-1:0]   last_count_reg, last_count_next;
    logic                 seen_reg, seen_next;
    logic [TIME_W-1:0]    last_time_reg, last_time_next;
    logic                 csum_fault_reg, csum_fault_next;
    logic                 tout_fault_reg, tout_fault_next;
    logic                 out_valid_reg, out_valid_next;
    status_t              status_reg, status_next;
    entry_t               data_reg;
    logic                 csum_flag_reg;
    logic                 tout_flag_reg;
    logic [TIME_W-1:0]    elapsed;
    logic                 do_pop;

    assign pop_ready = !out_valid_reg || result.ready;
    assign do_pop    = pop_valid && pop_ready;
    assign cfg.ready = 1'b1;
    assign elapsed   = pop_entry.now_ms - last_time_reg;

    always_comb
    begin
        timeout_next    = timeout_reg;
        last_count_next = last_count_reg;
        seen_next       = seen_reg;
        last_time_next  = last_time_reg;
        csum_fault_next = csum_fault_reg;
        tout_fault_next = tout_fault_reg;
        status_next     = STATUS_OK;
        out_valid_next  = out_valid_reg && !result.ready;
        if (cfg.valid)
        begin
            timeout_next = cfg.data;
        end
        if (do_pop)
        begin
            out_valid_next = 1'b1;
            case (pop_entry.kind)
                KIND_TICK:
                begin
                    if (seen_reg && (elapsed >= TIME_W'(timeout_reg)))
                    begin
                        tout_fault_next = 1'b1;
                    end
                end
                KIND_BAD:
                begin
                    csum_fault_next = 1'b1;
                    status_next     = STATUS_CSUM;
                end
                KIND_GOOD:
                begin
                    last_time_next  = pop_entry.now_ms;
                    tout_fault_next = 1'b0;
                    if (seen_reg && (pop_entry.rolling_count != last_count_reg + 1'b1))
                    begin
                        status_next = STATUS_GAP;
                    end
                    last_count_next = pop_entry.rolling_count;
                    seen_next       = 1'b1;
                end
                default:
                begin
                    status_next = STATUS_OK;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg    <= TIMEOUT_RESET;
            last_count_reg <= '0;
            seen_reg       <= 1'b0;
            last_time_reg  <= '0;
            csum_fault_reg <= 1'b0;
            tout_fault_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            timeout_reg    <= timeout_next;
            last_count_reg <= last_count_next;
            seen_reg       <= seen_next;
            last_time_reg  <= last_time_next;
            csum_fault_reg <= csum_fault_next;
            tout_fault_reg <= tout_fault_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_pop)
        begin
            status_reg    <= status_next;
            data_reg      <= pop_entry;
            csum_flag_reg <= csum_fault_next;
            tout_flag_reg <= tout_fault_next;
        end
    end

    assign result.valid               = out_valid_reg;
    assign result.status              = status_reg;
    assign result.gear_code           = data_reg.gear_code;
    assign result.speed_x10           = data_reg.speed_x10;
    assign result.throttle            = data_reg.throttle;
    assign result.sender_faults       = data_reg.sender_faults;
    assign result.rolling_count       = data_reg.rolling_count;
    assign result.checksum_fault_flag = csum_flag_reg;
    assign result.timeout_fault_flag  = tout_flag_reg;

    assign mon_status.seen_frame     = seen_reg;
    assign mon_status.checksum_fault = csum_fault_reg;
    assign mon_status.timeout_fault  = tout_fault_reg;

endmodule

// File: rtl/core/frame_checksum_counter_monitor_core.sv
// Top level of the frame checksum and rolling-counter monitor.
// Depends on fcm_pkg, the channel interfaces, fcm_front, fcm_queue and fcm_back.

// The monitor takes one word per clock cycle on the item channel while its
// queue has room, either an eight-byte status frame or a time tick, and returns
// exactly one result word for each, in order. A frame whose byte seven is not
// 0xFF minus the eight-bit sum of bytes zero to six sets the sticky checksum
// fault and is otherwise ignored; a good frame is unpacked, its time is
// recorded, the timeout fault is cleared and its rolling counter is checked
// against the previous one plus one, modulo sixteen. A tick sets the timeout
// fault once the time since the last good frame, modulo two to the thirty-two,
// reaches the timeout register. Throughput is one word per cycle while the
// queue has room: the front checks and classifies a word in the cycle it is
// accepted and writes it to a two-entry queue, and the back then applies it to
// the state and loads the output register, so a result is registered first in
// the queue and then in the output register. The item channel stalls only when
// the queue is full because results are not being taken. The timeout register
// resets to 100 ms and is written through the configuration channel, which is
// always ready and should be used only while no word is in flight.
module frame_checksum_counter_monitor_core import fcm_pkg::*; (
    input  logic         clk,
    input  logic         rst_n,
    fcm_item_if.sink     item,
    fcm_result_if.source result,
    fcm_cfg_if.sink      cfg
);

    logic        push_valid;
    logic        push_ready;
    entry_t      push_entry;
    logic        pop_valid;
    logic        pop_ready;
    entry_t      pop_entry;
    mon_status_t mon_status;

    // Classification of each accepted word happens here, in the accept cycle.
    fcm_front u_front (
        .item       (item),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry)
    );

    // The queue lets the front keep accepting while a result waits downstream.
    fcm_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_entry  (pop_entry)
    );

    // The back part holds all monitor state and the output register.
    fcm_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_entry  (pop_entry),
        .result     (result),
        .cfg        (cfg),
        .mon_status (mon_status)
    );

    // The checksum fault, once set, is only cleared by reset.
    assert property (@(posedge clk) disable iff (!rst_n)
        $past(mon_status.checksum_fault) |-> mon_status.checksum_fault)
        else $error("checksum fault cleared without reset");

    // A timeout can only have been raised after a good frame was seen.
    assert property (@(posedge clk) disable iff (!rst_n)
        mon_status.timeout_fault |-> mon_status.seen_frame)
        else $error("timeout fault set before any good frame");

    // A presented checksum error result always carries the sticky flag.
    assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && (result.status == STATUS_CSUM)) |-> result.checksum_fault_flag)
        else $error("checksum error result without checksum fault flag");

    // A counter gap result implies a good frame has been seen, and no timeout.
    assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && (result.status == STATUS_GAP))
        |-> (mon_status.seen_frame && !result.timeout_fault_flag))
        else $error("counter gap reported in an impossible state");

endmodule

// File: verif/fcm_checker.sv
// Checker for the frame checksum and rolling-counter monitor: it predicts each result
// word and compares it with what the block returns.
// Depends on fcm_pkg and on the channel interfaces in fcm_interfaces.sv.
module fcm_checker import fcm_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    fcm_item_if         item,
    fcm_result_if       result,
    fcm_cfg_if          cfg,
    output int unsigned mismatches,
    output int unsigned words_in_flight,
    output int unsigned gaps_seen,
    output int unsigned timeouts_seen
);

    typedef struct packed {
        status_t                 status;
        logic [FRAME_BYTE_W-1:0] gear;
        logic [SPEED_W-1:0]      speed;
        logic [FRAME_BYTE_W-1:0] throttle;
        logic [FRAME_BYTE_W-1:0] faults;
        logic [COUNT_W-1:0]      count;
        logic                    csum_flag;
        logic                    tmo_flag;
    } monitor_result_t;

    // Shadow copy of the monitor state and its timeout register.
    logic [TIMEOUT_W-1:0] timeout_ms;
    logic [COUNT_W-1:0]   last_count;
    logic                 seen_frame;
    logic [TIME_W-1:0]    last_good_ms;
    logic                 csum_fault;
    logic                 timeout_fault;

    monitor_result_t pending_results[$];

    task automatic apply_word(input command_t cmd, input logic [TIME_W-1:0] now,
                              input logic [7:0][FRAME_BYTE_W-1:0] bytes,
                              output monitor_result_t res);
        logic [FRAME_BYTE_W-1:0] sum;
        logic [TIME_W-1:0]       elapsed;
        res = '0;
        if (cmd == CMD_TICK) begin
            elapsed = now - last_good_ms;
            if (seen_frame && elapsed >= TIME_W'(timeout_ms))
                timeout_fault = 1'b1;
        end else begin
            sum = '0;
            for (int i = 0; i < 7; i++)
                sum = sum + bytes[i];
            if (bytes[7] != CSUM_BASE - sum) begin
                csum_fault = 1'b1;
                res.status = STATUS_CSUM;
            end else begin
                res.gear     = bytes[0];
                res.speed    = {bytes[2], bytes[1]};
                res.throttle = bytes[3];
                res.faults   = bytes[4];
                res.count    = bytes[6][COUNT_W-1:0];
                last_good_ms  = now;
                timeout_fault = 1'b0;
                if (seen_frame && res.count != last_count + 1'b1)
                    res.status = STATUS_GAP;
                last_count = res.count;
                seen_frame = 1'b1;
            end
        end
        res.csum_flag = csum_fault;
        res.tmo_flag  = timeout_fault;
    endtask

    task automatic check_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            mismatches++;
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                     $time, field, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        monitor_result_t predicted;
        monitor_result_t want;
        if (!rst_n) begin
            timeout_ms    = TIMEOUT_RESET;
            last_count    = '0;
            seen_frame    = 1'b0;
            last_good_ms  = '0;
            csum_fault    = 1'b0;
            timeout_fault = 1'b0;
            pending_results.delete();
            words_in_flight = 0;
        end else begin
            if (cfg.valid && cfg.ready)
                timeout_ms = cfg.data;
            if (item.valid && item.ready) begin
                apply_word(command_t'(item.command), item.now_ms,
                           {item.frame_byte7, item.frame_byte6, item.frame_byte5,
                            item.frame_byte4, item.frame_byte3, item.frame_byte2,
                            item.frame_byte1, item.frame_byte0}, predicted);
                pending_results.push_back(predicted);
            end
            if (result.valid && result.ready) begin
                if (pending_results.size() == 0) begin
                    mismatches++;
                    $display("%0t: stray result, expected nothing, actual status 0x%0h",
                             $time, result.status);
                end else begin
                    want = pending_results.pop_front();
                    check_field("status", 32'(want.status), 32'(result.status));
                    check_field("gear_code", 32'(want.gear), 32'(result.gear_code));
                    check_field("speed_x10", 32'(want.speed), 32'(result.speed_x10));
                    check_field("throttle", 32'(want.throttle), 32'(result.throttle));
                    check_field("sender_faults", 32'(want.faults),
                                32'(result.sender_faults));
                    check_field("rolling_count", 32'(want.count),
                                32'(result.rolling_count));
                    check_field("checksum_fault_flag", 32'(want.csum_flag),
                                32'(result.checksum_fault_flag));
                    check_field("timeout_fault_flag", 32'(want.tmo_flag),
                                32'(result.timeout_fault_flag));
                    if (want.status == STATUS_GAP)
                        gaps_seen++;
                    if (want.tmo_flag)
                        timeouts_seen++;
                end
            end
            words_in_flight = pending_results.size();
        end
    end

endmodule

// File: verif/tb_top.sv
// Top of the regression for the frame checksum and rolling-counter monitor: it drives
// frames, ticks and timeout settings and gives the verdict.
// Depends on fcm_pkg, fcm_interfaces.sv, the monitor RTL and fcm_checker.
module tb_top;
    import fcm_pkg::*;

    // One word on the item channel. Byte 0 sits in the lowest bits of the byte array.
    typedef struct packed {
        command_t                     cmd;
        logic [TIME_W-1:0]            now;
        logic [7:0][FRAME_BYTE_W-1:0] bytes;
    } monitor_word_t;

    logic clk = 1'b0;
    logic rst_n;

    fcm_item_if   item_ch();
    fcm_result_if result_ch();
    fcm_cfg_if    cfg_ch();

    int unsigned mismatches;
    int unsigned in_flight;
    int unsigned gaps_seen;
    int unsigned timeouts_seen;

    // Stimulus bookkeeping: the timeout currently programmed, a free-running notion
    // of time for frames, and what the last good frame carried, so that ticks can be
    // aimed at the timeout boundary and frames can follow the rolling counter.
    logic [TIMEOUT_W-1:0] timeout_cur;
    logic [TIME_W-1:0]    clock_ms;
    logic [TIME_W-1:0]    last_good_ms;
    logic [COUNT_W-1:0]   next_count;
    logic                 allow_idle;
    logic                 quiet;
    int unsigned          good_sent;
    int unsigned          bad_sent;
    int unsigned          ticks_sent;
    int unsigned          settings_used;

    frame_checksum_counter_monitor_core i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    fcm_checker i_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .item            (item_ch),
        .result          (result_ch),
        .cfg             (cfg_ch),
        .mismatches      (mismatches),
        .words_in_flight (in_flight),
        .gaps_seen       (gaps_seen),
        .timeouts_seen   (timeouts_seen)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // The checksum that makes a frame good: 0xFF minus the byte sum of bytes 0 to 6.
    function automatic logic [FRAME_BYTE_W-1:0] csum_of(
        input logic [7:0][FRAME_BYTE_W-1:0] bytes);
        logic [FRAME_BYTE_W-1:0] sum;
        sum = '0;
        for (int i = 0; i < 7; i++)
            sum = sum + bytes[i];
        return CSUM_BASE - sum;
    endfunction

    function automatic monitor_word_t good_frame(input logic [TIME_W-1:0] now,
                                                 input logic [7:0][FRAME_BYTE_W-1:0] body);
        monitor_word_t w;
        w.cmd      = CMD_FRAME;
        w.now      = now;
        w.bytes    = body;
        w.bytes[7] = csum_of(body);
        return w;
    endfunction

    // Random frame contents with a chosen rolling counter; the upper nibble of
    // byte 6 is left random, as the monitor must ignore it.
    function automatic logic [7:0][FRAME_BYTE_W-1:0] body_with_count(
        input logic [COUNT_W-1:0] cnt);
        logic [7:0][FRAME_BYTE_W-1:0] body;
        body = {$urandom(), $urandom()};
        body[6][COUNT_W-1:0] = cnt;
        return body;
    endfunction

    // A tick carries frame bytes too; they are randomised to show that they are ignored.
    function automatic monitor_word_t tick_at(input logic [TIME_W-1:0] now);
        monitor_word_t w;
        w.cmd   = CMD_TICK;
        w.now   = now;
        w.bytes = {$urandom(), $urandom()};
        return w;
    endfunction

    // Presents one word at a falling edge, sometimes after a burst of idle cycles,
    // and holds it until the monitor takes it. Returns at the falling edge after the
    // handshake, so the next word (or an idle) is driven from that edge.
    task automatic send_word(input monitor_word_t w);
        int gap;
        if (allow_idle && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 8);
            item_ch.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        item_ch.valid       = 1'b1;
        item_ch.command     = w.cmd;
        item_ch.now_ms      = w.now;
        item_ch.frame_byte0 = w.bytes[0];
        item_ch.frame_byte1 = w.bytes[1];
        item_ch.frame_byte2 = w.bytes[2];
        item_ch.frame_byte3 = w.bytes[3];
        item_ch.frame_byte4 = w.bytes[4];
        item_ch.frame_byte5 = w.bytes[5];
        item_ch.frame_byte6 = w.bytes[6];
        item_ch.frame_byte7 = w.bytes[7];
        @(posedge clk);
        while (!item_ch.ready)
            @(posedge clk);
        @(negedge clk);
        if (w.cmd == CMD_TICK) begin
            ticks_sent++;
        end else if (w.bytes[7] == csum_of(w.bytes)) begin
            good_sent++;
            last_good_ms = w.now;
            next_count   = w.bytes[6][COUNT_W-1:0] + 1'b1;
        end else begin
            bad_sent++;
        end
    endtask

    // Every word yields a result, so once the checker holds no expectation the
    // monitor is empty; the wait that follows covers the output register.
    task automatic wait_idle();
        item_ch.valid = 1'b0;
        while (in_flight != 0)
            @(negedge clk);
        repeat (2) @(negedge clk);
    endtask

    task automatic set_timeout(input logic [TIMEOUT_W-1:0] value);
        wait_idle();
        cfg_ch.valid = 1'b1;
        cfg_ch.data  = value;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        @(negedge clk);
        cfg_ch.valid = 1'b0;
        timeout_cur  = value;
        settings_used++;
    endtask

    // Random traffic. Most words are good frames that follow the rolling counter,
    // so the gap check and the timeout logic are exercised from a settled state;
    // the rest are frames with a jump in the counter, corrupted frames and ticks
    // placed on either side of the timeout boundary.
    task automatic run_phase(input int n_words);
        monitor_word_t     w;
        logic [TIME_W-1:0] limit;
        logic [TIME_W-1:0] offset;
        int                pick;
        for (int i = 0; i < n_words; i++) begin
            if (i % 64 == 0)
                allow_idle = !quiet && ($urandom_range(0, 3) != 0);
            limit = TIME_W'(timeout_cur);
            pick  = $urandom_range(0, 99);
            clock_ms = clock_ms + TIME_W'($urandom_range(0, 32'(timeout_cur) + 8));
            if (pick < 2) begin
                // Jump in time, sometimes to just before the wrap of the clock.
                if ($urandom_range(0, 1) == 0)
                    clock_ms = $urandom();
                else
                    clock_ms = 32'hFFFF_FFFF - TIME_W'($urandom_range(0, 300));
            end
            if (pick < 55) begin
                w = good_frame(clock_ms, body_with_count(next_count));
            end else if (pick < 63) begin
                w = good_frame(clock_ms, body_with_count(COUNT_W'($urandom_range(0, 15))));
            end else if (pick < 73) begin
                w = good_frame(clock_ms, {$urandom(), $urandom()});
                if ($urandom_range(0, 2) != 0)
                    w.bytes[7] ^= FRAME_BYTE_W'($urandom_range(1, 255));
                else
                    w.bytes[7] = FRAME_BYTE_W'($urandom());
            end else begin
                case ($urandom_range(0, 5))
                    0:       offset = limit - 1;
                    1:       offset = limit;
                    2:       offset = limit + 1;
                    3:       offset = TIME_W'($urandom_range(0, 2 * 32'(timeout_cur)));
                    4:       offset = $urandom();
                    default: offset = '0;
                endcase
                w = tick_at(last_good_ms + offset);
            end
            send_word(w);
        end
    endtask

    // Result side: the receiver stalls in random bursts while idling is allowed,
    // and takes every word at once otherwise.
    initial
    begin
        int stall;
        stall           = 0;
        result_ch.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (allow_idle && stall > 0) begin
                result_ch.ready = 1'b0;
                stall--;
            end else if (allow_idle && $urandom_range(0, 5) == 0) begin
                stall           = $urandom_range(1, 8) - 1;
                result_ch.ready = 1'b0;
            end else begin
                result_ch.ready = 1'b1;
            end
        end
    end

    initial
    begin
        monitor_word_t w;

        rst_n               = 1'b0;
        item_ch.valid       = 1'b0;
        item_ch.command     = CMD_FRAME;
        item_ch.now_ms      = '0;
        item_ch.frame_byte0 = '0;
        item_ch.frame_byte1 = '0;
        item_ch.frame_byte2 = '0;
        item_ch.frame_byte3 = '0;
        item_ch.frame_byte4 = '0;
        item_ch.frame_byte5 = '0;
        item_ch.frame_byte6 = '0;
        item_ch.frame_byte7 = '0;
        cfg_ch.valid        = 1'b0;
        cfg_ch.data         = '0;
        timeout_cur         = TIMEOUT_RESET;
        clock_ms            = '0;
        last_good_ms        = '0;
        next_count          = '0;
        allow_idle          = 1'b1;
        quiet               = 1'b0;
        good_sent           = 0;
        bad_sent            = 0;
        ticks_sent          = 0;
        settings_used       = 1;

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part, at the reset value of the timeout (100 ms).
        // Ticks before any good frame must leave the timeout fault clear,
        // even at the top of the time range.
        send_word(tick_at(32'd1000));
        send_word(tick_at(32'hFFFF_FFFF));
        // The all-zero frame with checksum 0xFF is the first good frame: no gap.
        send_word(good_frame(32'd0, 64'h0));
        // All data bytes at 0xFF, counter 1 with a set upper nibble.
        send_word(good_frame(32'd10, 64'h00F1_FFFF_FFFF_FFFF));
        // Checksum off by one bit, then an all-zero frame whose checksum is wrong.
        w = good_frame(32'd20, {$urandom(), $urandom()});
        w.bytes[7] ^= 8'h01;
        send_word(w);
        w.cmd   = CMD_FRAME;
        w.now   = 32'd25;
        w.bytes = '0;
        send_word(w);
        // A bad frame leaves the counter alone, so counter 2 follows on.
        send_word(good_frame(32'd30, 64'h0002_5A80_64AB_CD07));
        // Counter gaps: 2 to 7, 7 to 15; then 15 wraps to 0 without a gap.
        send_word(good_frame(32'd40, body_with_count(4'd7)));
        send_word(good_frame(32'd50, body_with_count(4'd15)));
        send_word(good_frame(32'd100, body_with_count(4'd0)));
        // Ticks one short of, at and one past the timeout.
        send_word(tick_at(32'd199));
        send_word(tick_at(32'd200));
        send_word(tick_at(32'd201));
        // A good frame clears the timeout fault; elapsed time then wraps past zero.
        send_word(good_frame(32'hFFFF_FFF0, body_with_count(4'd1)));
        send_word(tick_at(32'h0000_0053));
        send_word(tick_at(32'h0000_0054));
        // A bad frame keeps both faults as they are; then a gap from 1 to 3.
        w = good_frame(32'h0000_0058, {$urandom(), $urandom()});
        w.bytes[7] ^= 8'h80;
        send_word(w);
        send_word(good_frame(32'h0000_0060, body_with_count(4'd3)));

        // Random part over several timeout settings, the extremes among them,
        // including zero, at which every tick after a good frame raises the fault.
        set_timeout(16'd1);
        run_phase(300);
        set_timeout(16'hFFFF);
        run_phase(300);
        set_timeout(16'd0);
        run_phase(250);
        set_timeout(TIMEOUT_W'($urandom_range(2, 1000)));
        run_phase(300);
        // The last stretch runs with no idling on either side.
        set_timeout(TIMEOUT_W'($urandom_range(1, 65535)));
        quiet      = 1'b1;
        allow_idle = 1'b0;
        run_phase(500);

        wait_idle();
        repeat (4) @(posedge clk);

        $display("Covered %0d good frames, %0d frames with a bad checksum and %0d ticks",
                 good_sent, bad_sent, ticks_sent);
        $display("over %0d timeout settings; %0d counter gaps and %0d timed-out results seen.",
                 settings_used, gaps_seen, timeouts_seen);
        if (mismatches == 0 && in_flight == 0)
            $display("frame_checksum_counter_monitor_core regression: pass");
        else
            $display("frame_checksum_counter_monitor_core regression: fail");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run, with every word meeting the
    // longest idle bursts on both sides.
    initial
    begin
        #3000000;
        $display("frame_checksum_counter_monitor_core regression: fail");
        $finish;
    end

endmodule

// File: filelist.f
rtl/core/fcm_pkg.sv
rtl/core/fcm_interfaces.sv
rtl/core/fcm_front.sv
rtl/core/fcm_queue.sv
rtl/core/fcm_back.sv
rtl/core/frame_checksum_counter_monitor_core.sv
verif/fcm_checker.sv
verif/tb_top.sv
